/* hw/rtl/fmsp_pkg.sv */
// Shared constants, register map and config type for the four-motor speed PID.
`timescale 1ns / 1ps
`default_nettype none

package fmsp_pkg;

  // Loop count and frame ids
  localparam int MOTORS  = 4;
  localparam int FIELDS  = 4;
  localparam int ID_BASE = 513;
  localparam int MOTOR_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // Field widths
  localparam int ID_W    = 11;
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 24;
  localparam int DRIVE_W = 15;

  // Datapath widths
  localparam int E_W      = SPEED_W + 1;  // raw speed difference
  localparam int ERR_W    = 11;           // +-1000
  localparam int DER_W    = 16;           // +-30000
  localparam int INT_W    = 18;           // +-100000 tenths
  localparam int P_W      = 35;           // gain * err
  localparam int I_W      = 42;           // gain * integrator
  localparam int D_W      = 40;           // gain * derivative
  localparam int PCL_W    = 31;           // clamped P product
  localparam int SUM_W    = 46;
  localparam int SCALE_SH = 16;           // Q16.16 fraction bits
  localparam int SCALED_W = SUM_W - SCALE_SH;
  localparam int DIVN_W   = 17;           // dividend of the divide by ten
  localparam int REM_W    = 4;
  localparam int Q_W      = 14;
  localparam int CNT_W    = 5;

  // Limits
  localparam int ERR_LIMIT      = 1000;
  localparam int DER_STEP_LIMIT = 30;     // 30 * 1000 hits the derivative clamp
  localparam int DER_LIMIT      = 30000;
  localparam int INT_LIMIT      = 100000;
  localparam int P_LIMIT        = 655360000;  // 10000 in Q16.16
  localparam int OUT_LIMIT      = 10000;
  localparam int DIVN_MAX       = 100009;     // largest value that divides to 10000
  localparam int DIV_BASE       = 10;

  // Register map
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int REG_W  = 3;
  localparam logic [REG_W-1:0] REG_KP   = 3'd0;
  localparam logic [REG_W-1:0] REG_KI   = 3'd1;
  localparam logic [REG_W-1:0] REG_KD   = 3'd2;
  localparam logic [REG_W-1:0] REG_TGT0 = 3'd3;

  // Reset values
  localparam logic [GAIN_W-1:0] KP_RESET = 24'd458752;
  localparam logic [GAIN_W-1:0] KI_RESET = 24'd32768;
  localparam logic [GAIN_W-1:0] KD_RESET = 24'd7;
  localparam int TGT_RESET_EVEN = -2304;
  localparam int TGT_RESET_ODD  = 2304;

  typedef struct packed {
    logic [GAIN_W-1:0]              kp;
    logic [GAIN_W-1:0]              ki;
    logic [GAIN_W-1:0]              kd;
    logic [MOTORS-1:0][SPEED_W-1:0] tgt;
  } fmsp_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/four_motor_speed_pid_top.sv */
// Four-motor speed PID: feedback capture, serial PID per motor, result register.
// Feedback beat: stored if its id matches, no result; the next beat can follow at once.
// Tick beat: per motor, a shift-add over the gain bits, a bit-serial divide by ten and five
// single steps; the result register is loaded after the last motor.
// in_ready stays low from the tick until the result is loaded, longer under an output stall.
// Reset (synchronous, active high) zeroes speeds and integrators and loads default gains.
`timescale 1ns / 1ps
`default_nettype none

module four_motor_speed_pid_top import fmsp_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ADDR_W-1:0]         paddr,
  input  wire logic [DATA_W-1:0]         pwdata,
  output logic      [DATA_W-1:0]         prdata,
  output logic                           pready,
  // input channel
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      action,
  input  wire logic        [ID_W-1:0]    frame_id,
  input  wire logic signed [SPEED_W-1:0] speed_reading,
  // output channel
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed      [DRIVE_W-1:0] drive_motor_0,
  output logic signed      [DRIVE_W-1:0] drive_motor_1,
  output logic signed      [DRIVE_W-1:0] drive_motor_2,
  output logic signed      [DRIVE_W-1:0] drive_motor_3
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_INTEG = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SUM1  = 4'd4;
  localparam logic [3:0] S_SUM2  = 4'd5;
  localparam logic [3:0] S_MAG   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  fmsp_cfg_t cfg;

  logic [3:0]         state;
  logic [MOTOR_W-1:0] motor;
  logic [CNT_W-1:0]   bit_cnt;

  // per-motor loop state
  logic signed [SPEED_W-1:0] meas  [MOTORS];
  logic signed [SPEED_W-1:0] prev  [MOTORS];
  logic signed [INT_W-1:0]   integ [MOTORS];

  // datapath registers
  logic signed [ERR_W-1:0] err_r;
  logic signed [DER_W-1:0] der_r;
  logic signed [INT_W-1:0] acc_r;
  logic [GAIN_W-1:0]       kp_sh;
  logic [GAIN_W-1:0]       ki_sh;
  logic [GAIN_W-1:0]       kd_sh;
  logic signed [P_W-1:0]   p_acc;
  logic signed [I_W-1:0]   i_acc;
  logic signed [D_W-1:0]   d_acc;
  logic signed [SUM_W-1:0] sum_r;
  logic                    neg_r;
  logic signed [DRIVE_W-1:0] hold    [FIELDS];
  logic signed [DRIVE_W-1:0] drive_r [FIELDS];

  // combinational terms
  logic [ID_W:0]             id_diff;
  logic                      fb_hit;
  logic [MOTOR_W-1:0]        fb_idx;
  logic signed [SPEED_W-1:0] tgt_sel;
  logic signed [SPEED_W-1:0] meas_sel;
  logic signed [SPEED_W-1:0] prev_sel;
  logic signed [INT_W-1:0]   integ_sel;
  logic signed [E_W-1:0]     e_raw;
  logic signed [E_W-1:0]     d_raw;
  logic signed [DER_W-1:0]   d_x;
  logic signed [ERR_W-1:0]   err_c;
  logic signed [DER_W-1:0]   der_c;
  logic signed [INT_W:0]     a_raw;
  logic signed [INT_W-1:0]   acc_c;
  logic signed [P_W-1:0]     p_add;
  logic signed [I_W-1:0]     i_add;
  logic signed [D_W-1:0]     d_add;
  logic signed [PCL_W-1:0]   p_cl;
  logic [SUM_W-1:0]          mag;
  logic [SCALED_W-1:0]       scaled;
  logic [DIVN_W-1:0]         div_n;
  logic                      div_start;
  logic                      div_done;
  logic [Q_W-1:0]            div_q;
  logic signed [DRIVE_W-1:0] cmd_c;

  fmsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);

  // Feedback frame id decode
  assign id_diff = {1'b0, frame_id} - (ID_W+1)'(ID_BASE);
  assign fb_hit  = !id_diff[ID_W] && (id_diff < (ID_W+1)'(MOTORS));
  assign fb_idx  = id_diff[MOTOR_W-1:0];

  // Selected motor operands
  assign tgt_sel   = $signed(cfg.tgt[motor]);
  assign meas_sel  = meas[motor];
  assign prev_sel  = prev[motor];
  assign integ_sel = integ[motor];

  // Error and derivative with clamps
  always_comb begin
    e_raw = E_W'(tgt_sel) - E_W'(meas_sel);
    d_raw = E_W'(meas_sel) - E_W'(prev_sel);
    d_x   = DER_W'($signed(d_raw[7:0]));
    if (e_raw > ERR_LIMIT) begin
      err_c = ERR_W'(ERR_LIMIT);
    end else if (e_raw < -ERR_LIMIT) begin
      err_c = ERR_W'(-ERR_LIMIT);
    end else begin
      err_c = ERR_W'(e_raw);
    end
    // times 1000 as 1024 - 16 - 8
    if (d_raw > DER_STEP_LIMIT) begin
      der_c = DER_W'(DER_LIMIT);
    end else if (d_raw < -DER_STEP_LIMIT) begin
      der_c = DER_W'(-DER_LIMIT);
    end else begin
      der_c = (d_x <<< 10) - (d_x <<< 4) - (d_x <<< 3);
    end
  end

  // Integrator update with clamp
  always_comb begin
    a_raw = (INT_W+1)'(integ_sel) + (INT_W+1)'(err_r);
    if (a_raw > INT_LIMIT) begin
      acc_c = INT_W'(INT_LIMIT);
    end else if (a_raw < -INT_LIMIT) begin
      acc_c = INT_W'(-INT_LIMIT);
    end else begin
      acc_c = INT_W'(a_raw);
    end
  end

  // Shift-add terms, one gain bit per cycle, MSB first
  always_comb begin
    p_add = kp_sh[GAIN_W-1] ? P_W'(err_r) : P_W'(0);
    i_add = ki_sh[GAIN_W-1] ? I_W'(acc_r) : I_W'(0);
    d_add = kd_sh[GAIN_W-1] ? D_W'(der_r) : D_W'(0);
  end

  // P clamp
  always_comb begin
    if (p_acc > P_LIMIT) begin
      p_cl = PCL_W'(P_LIMIT);
    end else if (p_acc < -P_LIMIT) begin
      p_cl = PCL_W'(-P_LIMIT);
    end else begin
      p_cl = PCL_W'(p_acc);
    end
  end

  // Magnitude, drop Q16.16 fraction, clamp before the divide by ten
  always_comb begin
    mag    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    scaled = mag[SUM_W-1:SCALE_SH];
    div_n  = (scaled > SCALED_W'(DIVN_MAX)) ? DIVN_W'(DIVN_MAX) : scaled[DIVN_W-1:0];
  end

  assign div_start = (state == S_MAG);

  fmsp_div10 u_div10 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cmd_c = neg_r ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  // Sequencer and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      motor     <= '0;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < MOTORS; k++) begin
        meas[k]  <= '0;
        prev[k]  <= '0;
        integ[k] <= '0;
      end
    end else begin
      // result beat: raised when loaded, dropped when taken
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (action) begin
              motor <= '0;
              state <= S_LOAD;
            end else if (fb_hit) begin
              meas[fb_idx] <= speed_reading;
            end
          end
        end
        S_LOAD: begin
          prev[motor] <= meas_sel;
          state       <= S_INTEG;
        end
        S_INTEG: begin
          integ[motor] <= acc_c;
          bit_cnt      <= '0;
          state        <= S_MUL;
        end
        S_MUL: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == CNT_W'(GAIN_W-1)) begin
            state <= S_SUM1;
          end
        end
        S_SUM1: state <= S_SUM2;
        S_SUM2: state <= S_MAG;
        S_MAG:  state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            if (motor == MOTOR_W'(MOTORS-1)) begin
              state <= S_OUT;
            end else begin
              motor <= motor + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        err_r <= err_c;
        der_r <= der_c;
      end
      S_INTEG: begin
        acc_r <= acc_c;
        p_acc <= '0;
        i_acc <= '0;
        d_acc <= '0;
        kp_sh <= cfg.kp;
        ki_sh <= cfg.ki;
        kd_sh <= cfg.kd;
      end
      S_MUL: begin
        p_acc <= (p_acc <<< 1) + p_add;
        i_acc <= (i_acc <<< 1) + i_add;
        d_acc <= (d_acc <<< 1) + d_add;
        kp_sh <= kp_sh << 1;
        ki_sh <= ki_sh << 1;
        kd_sh <= kd_sh << 1;
      end
      // sum in units of 1/655360: I + 10*P, then + 10*D
      S_SUM1: sum_r <= SUM_W'(i_acc) + (SUM_W'(p_cl) <<< 3) + (SUM_W'(p_cl) <<< 1);
      S_SUM2: sum_r <= sum_r + (SUM_W'(d_acc) <<< 3) + (SUM_W'(d_acc) <<< 1);
      S_MAG:  neg_r <= sum_r[SUM_W-1];
      S_DIV: begin
        if (div_done) begin
          for (int k = 0; k < FIELDS; k++) begin
            if (k < MOTORS && int'(motor) == k) begin
              hold[k] <= cmd_c;
            end
          end
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          for (int k = 0; k < FIELDS; k++) begin
            drive_r[k] <= (k < MOTORS) ? hold[k] : DRIVE_W'(0);
          end
        end
      end
      default: ;
    endcase
  end

  assign drive_motor_0 = drive_r[0];
  assign drive_motor_1 = drive_r[1];
  assign drive_motor_2 = drive_r[2];
  assign drive_motor_3 = drive_r[3];

endmodule

`default_nettype wire

/* hw/rtl/fmsp_regs.sv */
// APB register file: PID gains and per-motor target speeds.
`timescale 1ns / 1ps
`default_nettype none

module fmsp_regs import fmsp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output fmsp_cfg_t              cfg
);

  logic [REG_W-1:0] idx;
  logic             wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp <= KP_RESET;
      cfg.ki <= KI_RESET;
      cfg.kd <= KD_RESET;
      for (int k = 0; k < MOTORS; k++) begin
        cfg.tgt[k] <= ((k & 1) != 0) ? SPEED_W'(TGT_RESET_ODD) : SPEED_W'(TGT_RESET_EVEN);
      end
    end else if (wr_en) begin
      case (idx)
        REG_KP:  cfg.kp <= pwdata[GAIN_W-1:0];
        REG_KI:  cfg.ki <= pwdata[GAIN_W-1:0];
        REG_KD:  cfg.kd <= pwdata[GAIN_W-1:0];
        default: begin
          for (int k = 0; k < MOTORS; k++) begin
            if (k < FIELDS && idx == REG_W'(int'(REG_TGT0) + k)) begin
              cfg.tgt[k] <= pwdata[SPEED_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_KP:  prdata = DATA_W'(cfg.kp);
      REG_KI:  prdata = DATA_W'(cfg.ki);
      REG_KD:  prdata = DATA_W'(cfg.kd);
      default: begin
        for (int k = 0; k < MOTORS; k++) begin
          if (k < FIELDS && idx == REG_W'(int'(REG_TGT0) + k)) begin
            prdata = DATA_W'($signed(cfg.tgt[k]));
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/fmsp_div10.sv */
// Bit-serial restoring divider by ten, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fmsp_div10 import fmsp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIVN_W-1:0] dividend,
  output logic                   done,
  output logic      [Q_W-1:0]    quotient
);

  logic [DIVN_W-1:0] n_sh;
  logic [DIVN_W-1:0] q_sh;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [REM_W:0]    trial;
  logic              fits;

  // Trial subtract of the running remainder
  assign trial = {rem, n_sh[DIVN_W-1]};
  assign fits  = (trial >= (REM_W+1)'(DIV_BASE));

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVN_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      n_sh <= dividend;
      rem  <= '0;
    end else if (busy) begin
      n_sh <= n_sh << 1;
      rem  <= fits ? REM_W'(trial - (REM_W+1)'(DIV_BASE)) : trial[REM_W-1:0];
      q_sh <= {q_sh[DIVN_W-2:0], fits};
    end
  end

  assign quotient = q_sh[Q_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/fmsp_checker.sv */
// Port-level assertions for the four-motor speed PID, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fmsp_checker import fmsp_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      action,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [DRIVE_W-1:0] drive_motor_0,
  input wire logic signed [DRIVE_W-1:0] drive_motor_1,
  input wire logic signed [DRIVE_W-1:0] drive_motor_2,
  input wire logic signed [DRIVE_W-1:0] drive_motor_3
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Drive commands stay inside the saturation limits
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (drive_motor_0 <= OUT_LIMIT) && (drive_motor_0 >= -OUT_LIMIT) &&
      (drive_motor_1 <= OUT_LIMIT) && (drive_motor_1 >= -OUT_LIMIT) &&
      (drive_motor_2 <= OUT_LIMIT) && (drive_motor_2 >= -OUT_LIMIT) &&
      (drive_motor_3 <= OUT_LIMIT) && (drive_motor_3 >= -OUT_LIMIT))
    else $error("drive command out of range");

  // A feedback beat never produces a result
  a_feedback_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !action && !out_valid |=> !out_valid)
    else $error("result raised by a feedback beat");

  // A tick occupies the controller
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action |=> !in_ready)
    else $error("input taken right after a tick");

endmodule

bind four_motor_speed_pid_top fmsp_checker u_fmsp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .action        (action),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .drive_motor_0 (drive_motor_0),
  .drive_motor_1 (drive_motor_1),
  .drive_motor_2 (drive_motor_2),
  .drive_motor_3 (drive_motor_3)
);

`default_nettype wire
